>>> rtl/kslot_pkg.sv
package kslot_pkg;

  // Slots covered by one bitmap word
  localparam int unsigned WordBits = 64;

  // Configuration register indexes
  localparam logic CfgIdxEnable  = 1'b0;
  localparam logic CfgIdxMaxSlot = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_ADD   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UNSUPPORTED  = 3'd1,
    ST_INVALID      = 3'd2,
    ST_NONE_FREE    = 3'd3,
    ST_REKEY_FAILED = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EVAL = 1'b1
  } fsm_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the item, read its first word
    logic advance;  // step the allocate scan to the next word
    logic finish;   // commit the word, counters and result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;      // outcome of the item is known this cycle
    logic out_free;  // result register can take a new result
  } dp_status_t;

endpackage

>>> rtl/kslot_if.sv
interface kslot_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] slot;
  logic       rekey_ok;

  modport source (output valid, output cmd, output slot, output rekey_ok, input ready);
  modport sink   (input valid, input cmd, input slot, input rekey_ok, output ready);
endinterface

interface kslot_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] granted_slot;
  logic [7:0] used_count;
  logic [7:0] pool_count;

  modport source (output valid, output status, output granted_slot, output used_count,
                  output pool_count, input ready);
  modport sink   (input valid, input status, input granted_slot, input used_count,
                  input pool_count, output ready);
endinterface

>>> rtl/kslot_ctrl.sv
module kslot_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  kslot_pkg::dp_status_t  sts_i,
  output kslot_pkg::ctrl_cmd_t   cmd_o
);

  kslot_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kslot_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      kslot_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = kslot_pkg::FSM_EVAL;
        end
      end
      kslot_pkg::FSM_EVAL: begin
        if (!sts_i.done) begin
          cmd_o.advance = 1'b1;
        end else if (sts_i.out_free) begin
          // hold in EVAL while the previous result is still waiting
          cmd_o.finish = 1'b1;
          state_d      = kslot_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = kslot_pkg::FSM_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.done && sts_i.out_free)
    else $error("finish issued without a known outcome or room for the result");

  a_idle_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> in_ready_o)
    else $error("controller not ready after finishing an item");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.advance, cmd_o.finish}))
    else $error("more than one datapath command at once");
`endif

endmodule

>>> rtl/kslot_dp.sv
module kslot_dp #(
  parameter int unsigned SLOT_COUNT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  input  logic [1:0]            in_cmd_i,
  input  logic [7:0]            in_slot_i,
  input  logic                  in_rekey_ok_i,
  input  kslot_pkg::ctrl_cmd_t  cmd_i,
  output kslot_pkg::dp_status_t sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            out_status_o,
  output logic [7:0]            out_granted_slot_o,
  output logic [7:0]            out_used_count_o,
  output logic [7:0]            out_pool_count_o
);

  localparam int unsigned WB       = kslot_pkg::WordBits;
  localparam int unsigned MapWords = (SLOT_COUNT + WB - 1) / WB;
  localparam int unsigned AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned TopLimit = (SLOT_COUNT - 1 > 255) ? 255 : SLOT_COUNT - 1;

  // configuration
  logic       mke_q;
  logic [7:0] max_q;

  // captured item
  logic [1:0] cmd_q;
  logic [7:0] slot_q;
  logic       rekey_q;
  logic [1:0] word_q;

  // bitmap store; a word never written reads as all busy
  logic [WB-1:0] mem_q [MapWords];
  logic [MapWords-1:0] wvld_q;
  logic [WB-1:0] rdata_q;
  logic          rvld_q;
  logic [1:0]    rd_word;
  logic          rd_en;

  logic [7:0] used_q, pool_q;
  logic       out_valid_q;
  logic [2:0] out_status_q;
  logic [7:0] out_granted_q, out_used_q, out_pool_q;

  logic [7:0]    top;
  logic [1:0]    top_word;
  logic [WB-1:0] eff_word, range_mask, free_vec, wr_data;
  logic          hit;
  logic [5:0]    hit_pos;
  logic          busy_bit;
  logic          done;
  kslot_pkg::status_e status;
  logic          wr_en, used_inc, used_dec, pool_inc;
  logic [7:0]    granted;

  assign top      = (max_q > 8'(TopLimit)) ? 8'(TopLimit) : max_q;
  assign top_word = top[7:6];
  assign eff_word = rvld_q ? rdata_q : '1;
  assign busy_bit = eff_word[slot_q[5:0]];

  always_comb begin
    range_mask = (word_q < top_word) ? '1 : ({WB{1'b1}} >> (6'd63 - top[5:0]));
    if (word_q == 2'd0) begin
      range_mask[0] = 1'b0;
    end
    free_vec = ~eff_word & range_mask;
  end

  // lowest free slot in the current word
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        hit     = 1'b1;
        hit_pos = 6'(i);
      end
    end
  end

  always_comb begin
    done     = 1'b1;
    status   = kslot_pkg::ST_OK;
    wr_en    = 1'b0;
    wr_data  = eff_word;
    used_inc = 1'b0;
    used_dec = 1'b0;
    pool_inc = 1'b0;
    granted  = '0;
    if (!mke_q) begin
      status = kslot_pkg::ST_UNSUPPORTED;
    end else begin
      case (cmd_q)
        kslot_pkg::CMD_ALLOC: begin
          if (hit) begin
            wr_en            = 1'b1;
            wr_data[hit_pos] = 1'b1;
            used_inc         = 1'b1;
            granted          = {word_q, hit_pos};
          end else if (word_q == top_word) begin
            status = kslot_pkg::ST_NONE_FREE;
          end else begin
            done = 1'b0;
          end
        end
        kslot_pkg::CMD_FREE, kslot_pkg::CMD_ADD: begin
          if (slot_q == 8'd0 || slot_q > top || !busy_bit) begin
            status = kslot_pkg::ST_INVALID;
          end else if (!rekey_q) begin
            status = kslot_pkg::ST_REKEY_FAILED;
          end else begin
            wr_en                  = 1'b1;
            wr_data[slot_q[5:0]]   = 1'b0;
            used_dec               = (cmd_q == kslot_pkg::CMD_FREE);
            pool_inc               = (cmd_q == kslot_pkg::CMD_ADD);
          end
        end
        default: begin
          status = kslot_pkg::ST_INVALID;
        end
      endcase
    end
  end

  assign sts_o.done     = done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign rd_en   = cmd_i.load || cmd_i.advance;
  assign rd_word = cmd_i.load
                 ? ((in_cmd_i == kslot_pkg::CMD_ALLOC) ? 2'd0 : in_slot_i[7:6])
                 : word_q + 2'd1;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[AW'(rd_word)];
    end
    if (cmd_i.finish && wr_en) begin
      mem_q[AW'(word_q)] <= wr_data;
    end
    if (cmd_i.load) begin
      cmd_q   <= in_cmd_i;
      slot_q  <= in_slot_i;
      rekey_q <= in_rekey_ok_i;
    end
    if (rd_en) begin
      word_q <= rd_word;
    end
    if (cmd_i.finish) begin
      out_status_q  <= 3'(status);
      out_granted_q <= granted;
      out_used_q    <= used_inc ? ((used_q != 8'hFF) ? used_q + 8'd1 : used_q)
                               : ((used_dec && used_q != 8'd0) ? used_q - 8'd1 : used_q);
      out_pool_q    <= (pool_inc && pool_q != 8'hFF) ? pool_q + 8'd1 : pool_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mke_q       <= 1'b0;
      max_q       <= '0;
      wvld_q      <= '0;
      rvld_q      <= 1'b0;
      used_q      <= '0;
      pool_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == kslot_pkg::CfgIdxEnable) begin
          mke_q <= cfg_data_i[0];
        end else begin
          max_q <= cfg_data_i;
        end
      end
      if (rd_en) begin
        rvld_q <= wvld_q[AW'(rd_word)];
      end
      if (cmd_i.finish) begin
        if (wr_en) begin
          wvld_q[AW'(word_q)] <= 1'b1;
        end
        if (used_inc && used_q != 8'hFF) begin
          used_q <= used_q + 8'd1;
        end else if (used_dec && used_q != 8'd0) begin
          used_q <= used_q - 8'd1;
        end
        if (pool_inc && pool_q != 8'hFF) begin
          pool_q <= pool_q + 8'd1;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_granted_slot_o = out_granted_q;
  assign out_used_count_o   = out_used_q;
  assign out_pool_count_o   = out_pool_q;

`ifndef NO_ASSERTIONS
  a_result_follows_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("no result after finishing an item");

  a_counts_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.finish |=> $stable(used_q) && $stable(pool_q))
    else $error("slot counters moved without a finished item");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> cmd_q == kslot_pkg::CMD_ALLOC && word_q != top_word)
    else $error("allocate scan stepped past the last usable word");

  a_grant_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_granted_q != 8'd0 |-> out_status_q == 3'(kslot_pkg::ST_OK))
    else $error("slot granted with a failing status");
`endif

endmodule

>>> rtl/key_slot_bitmap_allocator.sv
// Channel   Role    Handshake     Payload
// req_i     sink    valid/ready   cmd[1:0], slot[7:0], rekey_ok
// rsp_o     source  valid/ready   status[2:0], granted_slot[7:0], used_count[7:0],
//                                 pool_count[7:0]
// cfg       write   cfg_we_i      cfg_idx_i (0 enable, 1 max slot), cfg_data_i[7:0]
//
// One item at a time. Accept reads the first bitmap word. Free and add finish in
// the EVAL state, once the result register has room. Allocate scans one 64-slot
// word per cycle up to the word holding the highest usable slot.
// The single-ported bitmap store and its registered read set the pace.
// Reset marks every slot busy via per-word written flags; no clearing pass.
// A finished result waits in the output register; the next item is accepted
// meanwhile and stalls only at its own finish if the result is still untaken.
module key_slot_bitmap_allocator #(
  parameter int unsigned SLOT_COUNT = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [7:0]   cfg_data_i,
  kslot_req_if.sink    req_i,
  kslot_rsp_if.source  rsp_o
);

  kslot_pkg::ctrl_cmd_t  ctrl_cmd;
  kslot_pkg::dp_status_t dp_sts;

  // sequence: accept, step the scan, commit
  kslot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  // bitmap store, counters, configuration and result register
  kslot_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_cmd_i           (req_i.cmd),
    .in_slot_i          (req_i.slot),
    .in_rekey_ok_i      (req_i.rekey_ok),
    .cmd_i              (ctrl_cmd),
    .sts_o              (dp_sts),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .out_status_o       (rsp_o.status),
    .out_granted_slot_o (rsp_o.granted_slot),
    .out_used_count_o   (rsp_o.used_count),
    .out_pool_count_o   (rsp_o.pool_count)
  );

endmodule

>>> tb/kslot_result_checker.sv
module kslot_result_checker
  import kslot_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  kslot_req_if        req_i,
  kslot_rsp_if        rsp_i,
  output int unsigned outstanding_o,
  output int unsigned error_count_o
);

  typedef struct packed {
    status_e    status;
    logic [7:0] granted_slot;
    logic [7:0] used_count;
    logic [7:0] pool_count;
  } slot_result_t;

  logic [SLOT_COUNT-1:0] slot_busy;
  logic [7:0]            used_slots;
  logic [7:0]            pooled_slots;
  logic                  multi_key_en;
  logic [7:0]            max_slot;
  slot_result_t          awaited_results[$];
  int unsigned           errors;

  // Apply one request to the slot map and queue the result it must produce.
  task automatic predict_slot_result(input logic [1:0] cmd, input logic [7:0] slot,
                                     input logic rekey_ok);
    slot_result_t res;
    int unsigned  top;
    int unsigned  k;
    logic         found;
    res.status       = ST_OK;
    res.granted_slot = '0;
    top = 32'(max_slot);
    if (top > SLOT_COUNT - 1) top = SLOT_COUNT - 1;
    if (!multi_key_en) begin
      res.status = ST_UNSUPPORTED;
    end else if (cmd == CMD_ALLOC) begin
      res.status = ST_NONE_FREE;
      found = 1'b0;
      for (k = 1; k <= top; k++) begin
        if (!found && !slot_busy[k]) begin
          found = 1'b1;
          slot_busy[k] = 1'b1;
          if (used_slots != 8'hFF) used_slots++;
          res.granted_slot = k[7:0];
          res.status = ST_OK;
        end
      end
    end else if (cmd == CMD_FREE || cmd == CMD_ADD) begin
      if (slot == 0 || slot > top || !slot_busy[slot]) begin
        res.status = ST_INVALID;
      end else if (!rekey_ok) begin
        res.status = ST_REKEY_FAILED;
      end else begin
        slot_busy[slot] = 1'b0;
        if (cmd == CMD_FREE) begin
          if (used_slots != 8'h00) used_slots--;
        end else if (pooled_slots != 8'hFF) begin
          pooled_slots++;
        end
      end
    end else begin
      res.status = ST_INVALID;
    end
    res.used_count = used_slots;
    res.pool_count = pooled_slots;
    awaited_results.push_back(res);
  endtask

  task automatic compare_field(input string field, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t res;
    if (!rst_ni) begin
      slot_busy    = '1;
      used_slots   = '0;
      pooled_slots = '0;
      multi_key_en = 1'b0;
      max_slot     = '0;
      errors       = 0;
      awaited_results.delete();
      outstanding_o <= 0;
      error_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgIdxEnable) multi_key_en = cfg_data_i[0];
        else max_slot = cfg_data_i;
      end
      if (req_i.valid && req_i.ready) begin
        predict_slot_result(req_i.cmd, req_i.slot, req_i.rekey_ok);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none expected, actual status %0d slot %0d", $time,
                   rsp_i.status, rsp_i.granted_slot);
          errors++;
        end else begin
          res = awaited_results.pop_front();
          compare_field("status", 8'(res.status), 8'(rsp_i.status));
          compare_field("granted_slot", res.granted_slot, rsp_i.granted_slot);
          compare_field("used_count", res.used_count, rsp_i.used_count);
          compare_field("pool_count", res.pool_count, rsp_i.pool_count);
        end
      end
      outstanding_o <= awaited_results.size();
      error_count_o <= errors;
    end
  end

endmodule

>>> tb/key_slot_bitmap_allocator_tb.sv
module key_slot_bitmap_allocator_tb;
  import kslot_pkg::*;

  localparam int unsigned SlotCount   = 256;
  // cmd code with no meaning in the block; must answer invalid argument
  localparam logic [1:0]  CmdUnknown  = 2'd3;
  // Budget for the whole run, allowing on every item for an idle burst, the busy
  // time and a stalled result.
  localparam int unsigned CycleLimit  = 400000;
  // Quiet time at the end to catch any stray result
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseCount  = 8;
  // Phase that cycles one slot through allocate and add to drive the
  // in-use count into saturation
  localparam int unsigned ChurnPhase  = 2;
  localparam int unsigned ChurnPairs  = 270;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [7:0]  cfg_data;
  int unsigned outstanding;
  int unsigned error_count;
  int unsigned req_idle_pct = 0;
  int unsigned rsp_idle_pct = 0;
  int unsigned cycle_count  = 0;

  kslot_req_if req_if ();
  kslot_rsp_if rsp_if ();

  key_slot_bitmap_allocator #(
    .SLOT_COUNT(SlotCount)
  ) i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  kslot_result_checker #(
    .SLOT_COUNT(SlotCount)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .outstanding_o(outstanding),
    .error_count_o(error_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: hold ready low for random bursts, as often as the current
  // phase asks; otherwise take a result every cycle.
  initial begin
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item, optionally after an idle burst, and hold it until taken.
  // Valid stays high on return so back-to-back items follow without a gap.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] slot,
                           input logic rekey_ok);
    if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.cmd      <= cmd;
    req_if.slot     <= slot;
    req_if.rekey_ok <= rekey_ok;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write both registers on consecutive edges; upper enable bits get noise
  task automatic apply_setting(input logic enable, input logic [7:0] top);
    logic [6:0] pad;
    pad = 7'($urandom);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgIdxEnable;
    cfg_data <= {pad, enable};
    @(posedge clk);
    cfg_idx  <= CfgIdxMaxSlot;
    cfg_data <= top;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly in-range slots so that adds and frees land on real pool entries;
  // about one item in ten is raw noise over the full field ranges.
  task automatic send_random_item(input logic [7:0] top);
    int unsigned pick;
    logic [7:0]  slot;
    pick = $urandom_range(0, 99);
    if (top != 0 && $urandom_range(0, 9) != 0) slot = 8'($urandom_range(1, top));
    else slot = 8'($urandom);
    if (pick < 35) send_item(CMD_ADD, slot, $urandom_range(0, 9) != 0);
    else if (pick < 65) send_item(CMD_ALLOC, 8'($urandom), 1'($urandom));
    else if (pick < 90) send_item(CMD_FREE, slot, $urandom_range(0, 6) != 0);
    else send_item(2'($urandom), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    int unsigned p;
    int unsigned i;
    int unsigned count;
    logic        enable;
    logic [7:0]  top;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CfgIdxEnable;
    cfg_data        <= '0;
    req_if.valid    <= 1'b0;
    req_if.cmd      <= CMD_ALLOC;
    req_if.slot     <= '0;
    req_if.rekey_ok <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset multi-key is off: every command, even unknown, is unsupported
    req_idle_pct = 20;
    rsp_idle_pct = 20;
    send_item(CMD_ALLOC, 8'd0, 1'b1);
    send_item(CMD_FREE, 8'd1, 1'b1);
    send_item(CmdUnknown, 8'd255, 1'b0);
    wait_drained();

    // No usable slot at all
    apply_setting(1'b1, 8'd0);
    send_item(CMD_ALLOC, 8'd0, 1'b0);
    send_item(CMD_ADD, 8'd1, 1'b1);
    wait_drained();

    // Full slot range
    apply_setting(1'b1, 8'd255);
    send_item(CMD_FREE, 8'd5, 1'b1);     // busy from reset; in-use count holds at zero
    send_item(CMD_FREE, 8'd5, 1'b1);     // already free
    send_item(CMD_ADD, 8'd0, 1'b1);      // slot zero
    send_item(CMD_ADD, 8'd255, 1'b1);    // top slot into the pool
    send_item(CMD_ADD, 8'd255, 1'b1);    // already free
    send_item(CMD_ADD, 8'd10, 1'b0);     // programming failed, stays busy
    send_item(CMD_FREE, 8'd7, 1'b0);     // re-key failed, slot lost
    send_item(CmdUnknown, 8'd170, 1'b1);
    send_item(CMD_ALLOC, 8'd0, 1'b0);    // lowest free: 5
    send_item(CMD_ALLOC, 8'd0, 1'b0);    // scan through to the last word: 255
    send_item(CMD_ALLOC, 8'd0, 1'b0);    // none left
    send_item(CMD_ADD, 8'd64, 1'b1);
    send_item(CMD_ADD, 8'd63, 1'b1);     // word boundary pair
    send_item(CMD_ADD, 8'd128, 1'b1);
    send_item(CMD_ALLOC, 8'd0, 1'b0);    // 63
    send_item(CMD_ADD, 8'd63, 1'b1);     // add of an allocated slot
    send_item(CMD_FREE, 8'd64, 1'b1);
    send_item(CMD_ALLOC, 8'd0, 1'b0);    // 63 again
    wait_drained();

    // Random phases, each under its own setting and idle pressure
    for (p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin enable = 1'b1; top = 8'd6;   count = 100; req_idle_pct = 30; rsp_idle_pct = 30; end
        1: begin enable = 1'b1; top = 8'd255; count = 110; req_idle_pct = 0;  rsp_idle_pct = 0;  end
        2: begin enable = 1'b1; top = 8'd1;   count = 0;   req_idle_pct = 15; rsp_idle_pct = 25; end
        3: begin enable = 1'b0; top = 8'd20;  count = 30;  req_idle_pct = 20; rsp_idle_pct = 20; end
        4: begin enable = 1'b1; top = 8'd70;  count = 110; req_idle_pct = 40; rsp_idle_pct = 10; end
        5: begin enable = 1'b1; top = 8'd0;   count = 30;  req_idle_pct = 10; rsp_idle_pct = 40; end
        6: begin enable = 1'b1; top = 8'd140; count = 110; req_idle_pct = 30; rsp_idle_pct = 30; end
        default: begin
          // Final stretch runs flat out on both sides
          enable = 1'b1; top = 8'd8; count = 110; req_idle_pct = 0; rsp_idle_pct = 0;
        end
      endcase
      apply_setting(enable, top);
      if (p == ChurnPhase) begin
        // Allocate the single slot, then hand it back via add: each pair raises
        // both counts by one, well past saturation
        for (i = 0; i < ChurnPairs; i++) begin
          send_item(CMD_ALLOC, 8'($urandom), 1'($urandom));
          send_item(CMD_ADD, 8'd1, 1'b1);
        end
      end else begin
        for (i = 0; i < count; i++) send_random_item(top);
      end
      wait_drained();
    end

    // Catch any stray result, then judge
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/kslot_pkg.sv
rtl/kslot_if.sv
rtl/kslot_ctrl.sv
rtl/kslot_dp.sv
rtl/key_slot_bitmap_allocator.sv
tb/kslot_result_checker.sv
tb/key_slot_bitmap_allocator_tb.sv
